@@ rtl/bsr_pkg.sv @@
// ---------------------------------------------------------------------------
// bsr_pkg: shared types and constants for the button setpoint block
// Holds the transfer payload structs, configuration register indexes,
// reset values and the clamped step helper.
// ---------------------------------------------------------------------------
package bsr_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int SEQ_BITS_DEF   = 32;
  localparam int CFG_W          = 16;
  localparam int PCT_W          = 7;
  localparam int SEQ_OUT_W      = 32;
  localparam int MAX_RES        = 4;
  localparam int CNT_W          = 3;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd200;
  localparam logic [CFG_W-1:0] RAMP_RESET     = 16'd10;
  localparam logic [PCT_W-1:0] STEP_RESET     = 7'd5;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_HOLD     = 3'd1,
    CFG_REPEAT   = 3'd2,
    CFG_RAMP     = 3'd3,
    CFG_STEP     = 3'd4
  } cfg_reg_t;

  // Received packet kinds; the two unused codes act as other packets.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_VALUE = 2'd1;

  typedef struct packed {
    logic       up_level;
    logic       down_level;
    logic [1:0] rx_event;
    logic [7:0] rx_value;
  } tick_t;

  typedef struct packed {
    logic                 is_send;
    logic [PCT_W-1:0]     percent;
    logic [SEQ_OUT_W-1:0] sequence_res;
    logic [PCT_W-1:0]     shown_percent;
    logic                 shown_changed;
    logic                 last;
  } res_t;

  // All result items of one tick, in delivery order from item[0].
  typedef struct packed {
    res_t [MAX_RES-1:0] item;
    logic [CNT_W-1:0]   count;
  } batch_t;

  // Raise or lower a target by one step, clamped to 0..100.
  function automatic logic [PCT_W-1:0] step_target(input logic [PCT_W-1:0] t,
                                                   input logic [PCT_W-1:0] s,
                                                   input logic down);
    logic [PCT_W:0] sum;
    logic [PCT_W-1:0] r;
    sum = {1'b0, t} + {1'b0, s};
    r = t;
    if (!down) begin
      if (t < PCT_MAX) begin
        r = (sum > {1'b0, PCT_MAX}) ? PCT_MAX : sum[PCT_W-1:0];
      end
    end else if (t != '0) begin
      r = (t > s) ? t - s : '0;
    end
    return r;
  endfunction

endpackage

@@ rtl/button_setpoint_with_ramp.sv @@
// ---------------------------------------------------------------------------
// button_setpoint_with_ramp: two-button setpoint with remote sync and ramp
// Debounces up/down buttons, applies short presses and auto-repeat, adopts
// remote values and ramps a displayed value toward the setpoint.
// ---------------------------------------------------------------------------
// Usage: each transfer on the tick channel is one millisecond tick carrying
// the raw active-low button levels and an optional received-packet event.
// Each tick yields one to four items on the res channel: zero to three send
// items (remote adoption, up button, down button, in that order) followed by
// one status item with last set.
// The first item of a tick is shown in the cycle after the tick transfer.
// A tick with only its status item is taken every cycle while res_stall is
// low; the result channel moves one item per cycle when not stalled, so a
// tick with send items holds the queue until all of its items have moved.
// The next tick is taken in the same cycle that the last item of the
// previous tick transfers.
// Reset (synchronous, active high) restores the default timings, clears the
// setpoint, display and sequence number, and empties the queue.
// When the receiver stalls, the current item holds and tick_stall rises as
// soon as the queue cannot take a new tick.
// Configuration writes take effect at the clock edge with cfg_write high;
// write them only while no tick is in flight.
// ---------------------------------------------------------------------------
module button_setpoint_with_ramp #(
  parameter int TIMER_BITS = bsr_pkg::TIMER_BITS_DEF,
  parameter int SEQ_BITS   = bsr_pkg::SEQ_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_stall,
  input  bsr_pkg::tick_t            tick,
  output logic                      res_valid,
  input  logic                      res_stall,
  output bsr_pkg::res_t             res,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data
);

  bsr_pkg::batch_t batch;
  logic            can_load;
  logic            accept;

  // A tick is taken only when the queue can hold all of its items.
  assign tick_stall = !can_load;
  assign accept     = tick_valid && can_load;

  bsr_core #(
    .TIMER_BITS(TIMER_BITS),
    .SEQ_BITS  (SEQ_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .tick     (tick),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .batch    (batch)
  );

  bsr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .batch    (batch),
    .can_load (can_load),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

@@ rtl/bsr_btn.sv @@
// ---------------------------------------------------------------------------
// bsr_btn: debounce and press decode for one button
// Takes the already advanced timers of one button and the shared repeat
// timer, and decides the new debounced level, timers and whether the
// target moves this tick.
// ---------------------------------------------------------------------------
module bsr_btn #(
  parameter int TIMER_BITS = bsr_pkg::TIMER_BITS_DEF
) (
  input  logic                         reading,
  input  logic                         raw_prev,
  input  logic                         stable,
  input  logic [TIMER_BITS-1:0]        settle,
  input  logic [TIMER_BITS-1:0]        press,
  input  logic [TIMER_BITS-1:0]        rep_in,
  input  logic [bsr_pkg::CFG_W-1:0]    debounce_ms,
  input  logic [bsr_pkg::CFG_W-1:0]    hold_ms,
  input  logic [bsr_pkg::CFG_W-1:0]    repeat_ms,
  output logic                         stable_next,
  output logic [TIMER_BITS-1:0]        settle_next,
  output logic [TIMER_BITS-1:0]        press_next,
  output logic [TIMER_BITS-1:0]        rep_out,
  output logic                         act
);

  localparam int CW = (TIMER_BITS > bsr_pkg::CFG_W) ? TIMER_BITS : bsr_pkg::CFG_W;

  logic fire;
  logic held;

  always_comb begin
    settle_next = (reading != raw_prev) ? '0 : settle;
    fire        = (CW'(settle_next) > CW'(debounce_ms)) && (reading != stable);
    stable_next = fire ? reading : stable;
    press_next  = press;
    rep_out     = rep_in;
    act         = 1'b0;
    if (fire) begin
      if (!reading) begin
        press_next = '0;
        rep_out    = '0;
      end else begin
        act     = CW'(press) < CW'(hold_ms);
        rep_out = '1;
      end
    end
    // A long press repeats once the shared timer runs past the interval.
    held = !stable_next && (CW'(press_next) >= CW'(hold_ms))
           && (CW'(rep_out) > CW'(repeat_ms));
    if (held) begin
      act     = 1'b1;
      rep_out = '0;
    end
  end

endmodule

@@ rtl/bsr_outq.sv @@
// ---------------------------------------------------------------------------
// bsr_outq: result queue for one tick's items
// Holds up to four result items, presented one per transfer, oldest first.
// A new batch loads when empty or as the previous one drains its last item.
// ---------------------------------------------------------------------------
module bsr_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  bsr_pkg::batch_t batch,
  output logic            can_load,
  output logic            res_valid,
  input  logic            res_stall,
  output bsr_pkg::res_t   res
);

  bsr_pkg::res_t [bsr_pkg::MAX_RES-1:0] slots;
  logic [bsr_pkg::CNT_W-1:0]            count;
  logic                                 pop;

  assign res_valid = (count != '0);
  assign res       = slots[0];
  assign pop       = res_valid && !res_stall;
  assign can_load  = (count == '0) || ((count == bsr_pkg::CNT_W'(1)) && !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - bsr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= batch.item;
    end else if (pop) begin
      for (int i = 0; i < bsr_pkg::MAX_RES - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bsr_pkg::CNT_W'(bsr_pkg::MAX_RES))
    else $error("result queue count out of range");

  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last == (count == bsr_pkg::CNT_W'(1))))
    else $error("status item not at the tail of its tick");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> res_valid)
    else $error("loaded batch not presented");

endmodule

@@ rtl/bsr_core.sv @@
// ---------------------------------------------------------------------------
// bsr_core: per-tick setpoint state update
// Holds configuration and state, and on each accepted tick applies the
// remote update, both buttons and the display ramp, building the batch of
// result items for that tick.
// ---------------------------------------------------------------------------
module bsr_core #(
  parameter int TIMER_BITS = bsr_pkg::TIMER_BITS_DEF,
  parameter int SEQ_BITS   = bsr_pkg::SEQ_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  bsr_pkg::tick_t           tick,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data,
  output bsr_pkg::batch_t          batch
);

  localparam int TW = TIMER_BITS;
  localparam int CW = (TW > bsr_pkg::CFG_W) ? TW : bsr_pkg::CFG_W;
  localparam int SW = (SEQ_BITS > bsr_pkg::SEQ_OUT_W) ? SEQ_BITS : bsr_pkg::SEQ_OUT_W;
  localparam int PW = bsr_pkg::PCT_W;

  // Configuration registers.
  logic [bsr_pkg::CFG_W-1:0] debounce_ms, hold_ms, repeat_ms, ramp_ms;
  logic [PW-1:0]             step_size;

  // Tick state.
  logic [PW-1:0]       remote_pct, target_pct, shown;
  logic [1:0]          raw_prev, stable;
  logic [TW-1:0]       settle0, settle1, press0, press1, rep_cnt, ramp_cnt;
  logic [SEQ_BITS-1:0] send_seq;

  logic [PW-1:0]       remote_next, t_rem, t_up, t_dn, shown_next;
  logic                rem_send, chg, ramp_fire;
  logic [1:0]          stable_next;
  logic [TW-1:0]       settle0_next, settle1_next, press0_next, press1_next;
  logic [TW-1:0]       rep_mid, rep_next, ramp_t, ramp_next;
  logic                act0, act1;
  logic [2:0]          send_v;
  logic [PW-1:0]       send_pct [3];
  logic [bsr_pkg::CNT_W-1:0] k;
  logic [SEQ_BITS-1:0] seq_next;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] t);
    return (&t) ? t : TW'(t + 1'b1);
  endfunction

  function automatic logic [bsr_pkg::SEQ_OUT_W-1:0] seq_word(input logic [SEQ_BITS-1:0] s);
    logic [SW-1:0] w;
    w = SW'(s);
    return w[bsr_pkg::SEQ_OUT_W-1:0];
  endfunction

  always_comb begin
    remote_next = remote_pct;
    if (tick.rx_event == bsr_pkg::EV_VALUE) begin
      remote_next = (tick.rx_value > 8'(bsr_pkg::PCT_MAX)) ? bsr_pkg::PCT_MAX
                                                            : tick.rx_value[PW-1:0];
    end
    rem_send = (tick.rx_event != bsr_pkg::EV_NONE) && (remote_next != target_pct);
    t_rem    = rem_send ? remote_next : target_pct;
  end

  bsr_btn #(.TIMER_BITS(TW)) u_btn_up (
    .reading    (tick.up_level),
    .raw_prev   (raw_prev[0]),
    .stable     (stable[0]),
    .settle     (sat_inc(settle0)),
    .press      (sat_inc(press0)),
    .rep_in     (sat_inc(rep_cnt)),
    .debounce_ms(debounce_ms),
    .hold_ms    (hold_ms),
    .repeat_ms  (repeat_ms),
    .stable_next(stable_next[0]),
    .settle_next(settle0_next),
    .press_next (press0_next),
    .rep_out    (rep_mid),
    .act        (act0)
  );

  bsr_btn #(.TIMER_BITS(TW)) u_btn_down (
    .reading    (tick.down_level),
    .raw_prev   (raw_prev[1]),
    .stable     (stable[1]),
    .settle     (sat_inc(settle1)),
    .press      (sat_inc(press1)),
    .rep_in     (rep_mid),
    .debounce_ms(debounce_ms),
    .hold_ms    (hold_ms),
    .repeat_ms  (repeat_ms),
    .stable_next(stable_next[1]),
    .settle_next(settle1_next),
    .press_next (press1_next),
    .rep_out    (rep_next),
    .act        (act1)
  );

  assign t_up = act0 ? bsr_pkg::step_target(t_rem, step_size, 1'b0) : t_rem;
  assign t_dn = act1 ? bsr_pkg::step_target(t_up, step_size, 1'b1) : t_up;

  // On ramp expiry the display moves one unit toward the tick's final target.
  always_comb begin
    ramp_t     = sat_inc(ramp_cnt);
    ramp_fire  = CW'(ramp_t) > CW'(ramp_ms);
    ramp_next  = ramp_fire ? '0 : ramp_t;
    shown_next = shown;
    chg        = 1'b0;
    if (ramp_fire) begin
      if (shown < t_dn) begin
        shown_next = shown + PW'(1);
        chg        = 1'b1;
      end else if (shown > t_dn) begin
        shown_next = shown - PW'(1);
        chg        = 1'b1;
      end
    end
  end

  // Pack the send items in order, then the status item.
  always_comb begin
    send_v      = {act1, act0, rem_send};
    send_pct[0] = t_rem;
    send_pct[1] = t_up;
    send_pct[2] = t_dn;
    batch       = '0;
    k           = '0;
    for (int i = 0; i < 3; i++) begin
      if (send_v[i]) begin
        batch.item[k[1:0]] = '{is_send: 1'b1, percent: send_pct[i],
                               sequence_res: seq_word(send_seq + SEQ_BITS'(k)),
                               shown_percent: shown, shown_changed: 1'b0,
                               last: 1'b0};
        k = k + bsr_pkg::CNT_W'(1);
      end
    end
    seq_next = send_seq + SEQ_BITS'(k);
    batch.item[k[1:0]] = '{is_send: 1'b0, percent: t_dn,
                           sequence_res: seq_word(seq_next),
                           shown_percent: shown_next, shown_changed: chg,
                           last: 1'b1};
    batch.count = k + bsr_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_pct <= '0;
      target_pct <= '0;
      shown      <= '0;
      raw_prev   <= 2'b11;
      stable     <= 2'b11;
      settle0    <= '0;
      settle1    <= '0;
      press0     <= '0;
      press1     <= '0;
      rep_cnt    <= '1;
      ramp_cnt   <= '0;
      send_seq   <= '0;
    end else if (accept) begin
      remote_pct <= remote_next;
      target_pct <= t_dn;
      shown      <= shown_next;
      raw_prev   <= {tick.down_level, tick.up_level};
      stable     <= stable_next;
      settle0    <= settle0_next;
      settle1    <= settle1_next;
      press0     <= press0_next;
      press1     <= press1_next;
      rep_cnt    <= rep_next;
      ramp_cnt   <= ramp_next;
      send_seq   <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= bsr_pkg::DEBOUNCE_RESET;
      hold_ms     <= bsr_pkg::HOLD_RESET;
      repeat_ms   <= bsr_pkg::REPEAT_RESET;
      ramp_ms     <= bsr_pkg::RAMP_RESET;
      step_size   <= bsr_pkg::STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bsr_pkg::CFG_DEBOUNCE: debounce_ms <= cfg_data;
        bsr_pkg::CFG_HOLD:     hold_ms     <= cfg_data;
        bsr_pkg::CFG_REPEAT:   repeat_ms   <= cfg_data;
        bsr_pkg::CFG_RAMP:     ramp_ms     <= cfg_data;
        bsr_pkg::CFG_STEP:     step_size   <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    target_pct <= bsr_pkg::PCT_MAX && remote_pct <= bsr_pkg::PCT_MAX)
    else $error("setpoint above full scale");

  a_shown_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> shown <= bsr_pkg::PCT_MAX)
    else $error("displayed value above full scale");

endmodule
